@@ rtl/core/npd_pkg.sv @@
// ----------------------------------------------------------------------------
// npd_pkg: nearest point distance package
// Fixed-point constants, CORDIC arctangent table and sequencer codes.
// ----------------------------------------------------------------------------
package npd_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int StepW = $clog2(CORDIC_STEPS);
  localparam int CW = 44;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] RADF =
    ((PI_Q60 / 64'd3515625) << 24) + (((PI_Q60 % 64'd3515625) << 24) / 64'd3515625);
  localparam logic signed [CW-1:0] PI_Q40 = CW'((PI_Q60 + (64'd1 << 19)) >> 20);
  localparam logic signed [CW-1:0] HALF_PI_Q40 = CW'((PI_Q60 + (64'd1 << 20)) >> 21);
  localparam logic signed [CW-1:0] GAIN_Q40 = 44'sd667681663043;
  localparam logic [63:0] TWO_R_MM = 64'd12756274000;
  localparam logic [38:0] START_MM = 39'd400000000000;
  localparam logic [81:0] ONE_Q80 = 82'd1 << 80;

  typedef logic signed [CW-1:0] atan_tab_t [CORDIC_STEPS];

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    logic [63:0] acc;
    logic [63:0] term;
    int sh;
    t[0] = CW'((PI_Q60 + (64'd1 << 21)) >> 22);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      acc = '0;
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 62) begin
          term = ((64'd1 << 62) >> sh) / 64'(2 * k + 1);
          if (k[0]) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
      t[i] = CW'((acc + (64'd1 << 21)) >> 22);
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MPOST,
    ST_RED,
    ST_ROT,
    ST_SQ_INIT,
    ST_SQRT,
    ST_VEC
  } state_e;

  typedef enum logic [2:0] {
    MOP_RAD,
    MOP_SA2,
    MOP_P,
    MOP_Q,
    MOP_QB,
    MOP_DIST
  } mop_e;

endpackage

@@ rtl/core/nearest_point_distance.sv @@
// ----------------------------------------------------------------------------
// nearest_point_distance: running minimum of haversine distances
// Shared 64x16 multiplier, CORDIC unit and bit-serial square root under
// one sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per point pair (tdata) with tlast ending a run.
//   Master channel: on an item with tlast, one item with the minimum
//   great-circle distance of the run in millimetres.
//   Each item runs four degree-to-radian products and four sine/cosine
//   rotations, four more products, two 41-step square roots, one
//   vectoring pass and the final scaling product. The multiplier forms
//   each product from 16-bit chunks of one operand. s_axis_tready is
//   high only while idle. The result sits in an output register after
//   the last step, so the next item is taken while it waits. If a new
//   result is ready while the old one is still not taken, the sequencer
//   holds.
//   Reset clears the output valid flag and sets the running minimum to 4e8 m.
// ----------------------------------------------------------------------------
module nearest_point_distance
  import npd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // ref_lat[30:0], ref_lon[62:31], pt_lat[93:63], pt_lon[125:94]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata   // min_distance_mm[38:0]
);

  state_e state_q, state_d;
  mop_e   mop_q;
  logic [1:0] ang_q;
  logic [1:0] mc_q;
  logic [127:0] acc_q;
  logic signed [32:0] dlat_q, dlon_q, rlat_q, plat_q;
  logic last_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic neg_q;
  logic [StepW-1:0] it_q;
  logic [CW-1:0] ua_q, ub_q, c1_q, c2_q;
  logic c1n_q, c2n_q;
  logic [81:0] hl_q;
  logic [41:0] p_q, qv_q;
  logic [CW-1:0] theta_q;
  logic [80:0] h_q;
  logic [82:0] rem_q;
  logic [40:0] root_q, m_q;
  logic [5:0] sbit_q;
  logic pass_q;
  logic [38:0] run_min_q;
  logic out_valid_q;
  logic [38:0] out_data_q;

  logic accept, out_free, it_last;
  logic [63:0] a_op, b_op;
  logic [15:0] b_chunk;
  logic [79:0] prod;
  logic [6:0] rsh;
  logic [127:0] rnd;
  logic signed [32:0] d_sel;
  logic [32:0] d_mag;
  logic signed [CW-1:0] r_sgn, dx, dy, at;
  logic signed [CW-1:0] xr, yr, zr, xv, yv, zv, s_res, c_res;
  logic [82:0] trial;
  logic [40:0] root_n;
  logic [82:0] rem_n;
  logic [38:0] dist_s, min_n;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign it_last  = (it_q == StepW'(CORDIC_STEPS - 1));

  always_comb begin
    case (ang_q)
      2'd0:    d_sel = dlat_q;
      2'd1:    d_sel = dlon_q;
      2'd2:    d_sel = rlat_q;
      default: d_sel = plat_q;
    endcase
  end
  assign d_mag = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);

  always_comb begin
    case (mop_q)
      MOP_RAD:  begin a_op = RADF;          b_op = 64'(d_mag);   end
      MOP_SA2:  begin a_op = 64'(ua_q);     b_op = 64'(ua_q);    end
      MOP_P:    begin a_op = 64'(c1_q);     b_op = 64'(c2_q);    end
      MOP_Q:    begin a_op = 64'(p_q);      b_op = 64'(ub_q);    end
      MOP_QB:   begin a_op = 64'(qv_q);     b_op = 64'(ub_q);    end
      default:  begin a_op = TWO_R_MM;      b_op = 64'(theta_q); end
    endcase
  end
  assign b_chunk = b_op[16*mc_q +: 16];
  assign prod    = a_op * b_chunk;

  assign rsh = (mop_q != MOP_RAD) ? 7'd40 : (ang_q[1] ? 7'd53 : 7'd54);
  assign rnd = (acc_q + (128'd1 << (rsh - 7'd1))) >> rsh;
  assign r_sgn = d_sel[32] ? -CW'(rnd) : CW'(rnd);

  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = ATAN_TAB[it_q];

  always_comb begin
    if (z_q >= 0) begin
      xr = x_q - dx; yr = y_q + dy; zr = z_q - at;
    end else begin
      xr = x_q + dx; yr = y_q - dy; zr = z_q + at;
    end
    if (y_q > 0) begin
      xv = x_q + dx; yv = y_q - dy; zv = z_q + at;
    end else begin
      xv = x_q - dx; yv = y_q + dy; zv = z_q - at;
    end
    s_res = neg_q ? -yr : yr;
    c_res = neg_q ? -xr : xr;
  end

  always_comb begin
    trial  = (83'(root_q) << (sbit_q + 6'd1)) | (83'd1 << {sbit_q, 1'b0});
    root_n = root_q;
    rem_n  = rem_q;
    if (trial <= rem_q) begin
      rem_n  = rem_q - trial;
      root_n = root_q | (41'd1 << sbit_q);
    end
  end

  assign dist_s = (rnd > 128'(START_MM)) ? START_MM : rnd[38:0];
  assign min_n  = (dist_s < run_min_q) ? dist_s : run_min_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept) state_d = ST_MUL;
      ST_MUL:     if (mc_q == 2'd3) state_d = ST_MPOST;
      ST_MPOST: begin
        case (mop_q)
          MOP_RAD: state_d = ST_RED;
          MOP_QB:  state_d = ST_SQ_INIT;
          MOP_DIST: if (!last_q || out_free) state_d = ST_IDLE;
          default: state_d = ST_MUL;
        endcase
      end
      ST_RED:     state_d = ST_ROT;
      ST_ROT:     if (it_last) state_d = ST_MUL;
      ST_SQ_INIT: state_d = ST_SQRT;
      ST_SQRT:    if (sbit_q == 6'd0) state_d = pass_q ? ST_VEC : ST_SQ_INIT;
      ST_VEC:     if (it_last) state_d = ST_MUL;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = {1'b0, out_data_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_min_q   <= START_MM;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MPOST && mop_q == MOP_DIST && last_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_MPOST && mop_q == MOP_DIST) begin
        if (!last_q) begin
          run_min_q <= min_n;
        end else if (out_free) begin
          run_min_q <= START_MM;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rlat_q <= 33'(signed'(s_axis_tdata[30:0]));
          plat_q <= 33'(signed'(s_axis_tdata[93:63]));
          dlat_q <= 33'(signed'(s_axis_tdata[30:0])) - 33'(signed'(s_axis_tdata[93:63]));
          dlon_q <= 33'(signed'(s_axis_tdata[62:31])) - 33'(signed'(s_axis_tdata[125:94]));
          last_q <= s_axis_tlast;
          mop_q  <= MOP_RAD;
          ang_q  <= 2'd0;
          mc_q   <= 2'd0;
          acc_q  <= '0;
        end
      end
      ST_MUL: begin
        acc_q <= acc_q + (128'(prod) << {mc_q, 4'd0});
        mc_q  <= mc_q + 2'd1;
      end
      ST_MPOST: begin
        if (state_d != ST_MPOST) begin
          mc_q  <= 2'd0;
          acc_q <= '0;
        end
        case (mop_q)
          MOP_RAD: z_q <= r_sgn;
          MOP_SA2: begin hl_q <= acc_q[81:0]; mop_q <= MOP_P; end
          MOP_P: begin
            p_q   <= (c1n_q != c2n_q) ? '0 : rnd[41:0];
            mop_q <= MOP_Q;
          end
          MOP_Q:  begin qv_q <= rnd[41:0]; mop_q <= MOP_QB; end
          MOP_QB: begin hl_q <= hl_q + acc_q[81:0]; pass_q <= 1'b0; end
          default: if (last_q && out_free) out_data_q <= min_n;
        endcase
      end
      ST_RED: begin
        x_q  <= GAIN_Q40;
        y_q  <= '0;
        it_q <= '0;
        if (z_q > HALF_PI_Q40) begin
          z_q <= z_q - PI_Q40; neg_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q40) begin
          z_q <= z_q + PI_Q40; neg_q <= 1'b1;
        end else begin
          neg_q <= 1'b0;
        end
      end
      ST_ROT: begin
        x_q  <= xr;
        y_q  <= yr;
        z_q  <= zr;
        it_q <= it_q + StepW'(1);
        if (it_last) begin
          case (ang_q)
            2'd0: ua_q <= s_res[CW-1] ? CW'(-s_res) : CW'(s_res);
            2'd1: ub_q <= s_res[CW-1] ? CW'(-s_res) : CW'(s_res);
            2'd2: begin c1_q <= c_res[CW-1] ? CW'(-c_res) : CW'(c_res); c1n_q <= c_res[CW-1]; end
            default: begin
              c2_q <= c_res[CW-1] ? CW'(-c_res) : CW'(c_res);
              c2n_q <= c_res[CW-1];
            end
          endcase
          ang_q <= ang_q + 2'd1;
          if (ang_q == 2'd3) mop_q <= MOP_SA2;
        end
      end
      ST_SQ_INIT: begin
        root_q <= '0;
        sbit_q <= 6'd40;
        if (!pass_q) begin
          h_q   <= (hl_q > ONE_Q80) ? ONE_Q80[80:0] : hl_q[80:0];
          rem_q <= (hl_q > ONE_Q80) ? 83'(ONE_Q80) : 83'(hl_q);
        end else begin
          rem_q <= 83'(ONE_Q80[80:0] - h_q);
        end
      end
      ST_SQRT: begin
        root_q <= root_n;
        rem_q  <= rem_n;
        sbit_q <= sbit_q - 6'd1;
        if (sbit_q == 6'd0) begin
          if (!pass_q) begin
            m_q    <= root_n;
            pass_q <= 1'b1;
          end else begin
            x_q  <= CW'(root_n);
            y_q  <= CW'(m_q);
            z_q  <= '0;
            it_q <= '0;
          end
        end
      end
      ST_VEC: begin
        x_q  <= xv;
        y_q  <= yv;
        z_q  <= zv;
        it_q <= it_q + StepW'(1);
        if (it_last) begin
          theta_q <= zv[CW-1] ? '0 : CW'(zv);
          mop_q   <= MOP_DIST;
          mc_q    <= 2'd0;
          acc_q   <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_rose_from_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_MPOST && mop_q == MOP_DIST))
    else $error("result without final scaling step");
  a_min_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_min_q <= START_MM)
    else $error("running minimum above start value");
  a_out_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38:0] <= START_MM))
    else $error("result above saturation value");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready while an item is in work");
  a_sqrt_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (root_q <= 41'h100_0000_0000))
    else $error("square root out of range");
`endif

endmodule
